// File: src/hse_pkg.sv
// Shared constants and types for the heap sort engine.
package hse_pkg;

    localparam int DEPTH = 64;
    localparam int DW    = 32;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int XW    = AW + 2;

    typedef logic signed [DW-1:0] t_word;
    typedef logic [AW-1:0]        t_addr;
    typedef logic [CW-1:0]        t_count;
    typedef logic [XW-1:0]        t_child;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH,
        S_GRAB,
        S_CMP,
        S_EMIT1,
        S_EMIT2
    } t_state;

    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_word wdata;
        t_addr raddr_a;
        t_addr raddr_b;
    } t_ram_req;

endpackage

// File: src/hse_ram.sv
// Sort buffer memory: one write port, two registered read ports.
module hse_ram (
    input  logic              i_clk,
    input  hse_pkg::t_ram_req i_req,
    output hse_pkg::t_word    o_rdata_a,
    output hse_pkg::t_word    o_rdata_b
);
    import hse_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rdata_a;
    t_word r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata_a <= r_mem[i_req.raddr_a];
        r_rdata_b <= r_mem[i_req.raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// File: src/heap_sort_engine.sv
// Heap sort engine top level: load control, min-heap sift sequencer and output register.
//
// Input channel (i_valid, o_stall, i_value, i_last): one signed value per item.
// Items are stored until an item marked last arrives, or until the item that
// fills the 64-entry buffer arrives; that item closes the set.
// o_stall is high from the closing item until the final result is in the
// output register; no item is taken while the set is sorted or emitted.
// Output channel (o_valid, i_stall, o_value_res, o_last_res): the set in
// ascending order, o_last_res high on the largest value.
// While loading, each item is written into the buffer as it is taken. After the
// closing item a min-heap is built in the buffer memory: each sift step reads
// both children, compares them and moves one entry up; each build node is first
// fetched through S_FETCH and S_GRAB. Each result is read from the root through
// S_EMIT1 and S_EMIT2, then the last entry sifts down one heap level per step.
// A stalled receiver holds the output register; the engine waits with it.
// Reset clears the element count and the output valid; buffer contents are
// not cleared and need no sweep.
module heap_sort_engine (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  hse_pkg::t_word i_value,
    input  logic           i_last,
    output logic           o_valid,
    input  logic           i_stall,
    output hse_pkg::t_word o_value_res,
    output logic           o_last_res
);
    import hse_pkg::*;

    t_state   r_state, n_state;
    t_count   r_cnt, n_cnt;
    t_count   r_size, n_size;
    t_addr    r_node, n_node;
    t_addr    r_start, n_start;
    logic     r_build, n_build;
    t_word    r_val, n_val;
    logic     r_ov, n_ov;
    t_word    r_out_val, n_out_val;
    logic     r_out_last, n_out_last;

    t_ram_req ram_req;
    t_word    rd_a;
    t_word    rd_b;

    t_count   load_n;
    t_child   lc;
    t_child   rc;
    logic     lc_ok;
    logic     rc_ok;
    logic     pick_r;
    t_word    cand;
    t_child   cand_idx;
    t_child   cand_lc;
    logic     move;
    logic     out_free;
    logic     in_acc;

    hse_ram u_ram (
        .i_clk    (i_clk),
        .i_req    (ram_req),
        .o_rdata_a(rd_a),
        .o_rdata_b(rd_b)
    );

    assign in_acc   = i_valid && (r_state == S_LOAD);
    assign out_free = !r_ov || !i_stall;
    assign load_n   = r_cnt + CW'(1);

    assign lc       = {1'b0, r_node, 1'b1};
    assign rc       = lc + XW'(1);
    assign lc_ok    = lc < XW'(r_size);
    assign rc_ok    = rc < XW'(r_size);
    assign pick_r   = rc_ok && (rd_b < rd_a);
    assign cand     = pick_r ? rd_b : rd_a;
    assign cand_idx = pick_r ? rc : lc;
    assign cand_lc  = {cand_idx[XW-2:0], 1'b1};
    assign move     = lc_ok && (cand < r_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_size  <= '0;
            r_node  <= '0;
            r_start <= '0;
            r_build <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_size  <= n_size;
            r_node  <= n_node;
            r_start <= n_start;
            r_build <= n_build;
            r_ov    <= n_ov;
        end
        r_val      <= n_val;
        r_out_val  <= n_out_val;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_size     = r_size;
        n_node     = r_node;
        n_start    = r_start;
        n_build    = r_build;
        n_val      = r_val;
        n_ov       = r_ov && i_stall;
        n_out_val  = r_out_val;
        n_out_last = r_out_last;
        ram_req    = '{we: 1'b0, waddr: r_node, wdata: r_val,
                       raddr_a: lc[AW-1:0], raddr_b: rc[AW-1:0]};

        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = r_cnt[AW-1:0];
                    ram_req.wdata = i_value;
                    n_cnt         = load_n;
                    if (i_last || (r_cnt == CW'(DEPTH - 1))) begin
                        n_cnt  = '0;
                        n_size = load_n;
                        if (load_n > CW'(1)) begin
                            n_start = AW'((load_n >> 1) - CW'(1));
                            n_node  = AW'((load_n >> 1) - CW'(1));
                            n_build = 1'b1;
                            n_state = S_FETCH;
                        end else begin
                            n_build = 1'b0;
                            n_state = S_EMIT1;
                        end
                    end
                end
            end
            S_FETCH: begin
                ram_req.raddr_a = r_node;
                n_state         = S_GRAB;
            end
            S_GRAB: begin
                n_val   = rd_a;
                n_state = S_CMP;
            end
            S_CMP: begin
                ram_req.we = 1'b1;
                if (move) begin
                    ram_req.wdata   = cand;
                    ram_req.raddr_a = cand_lc[AW-1:0];
                    ram_req.raddr_b = AW'(cand_lc + XW'(1));
                    n_node          = cand_idx[AW-1:0];
                end else begin
                    ram_req.wdata = r_val;
                    if (r_build && (r_start != '0)) begin
                        n_start = r_start - AW'(1);
                        n_node  = r_start - AW'(1);
                        n_state = S_FETCH;
                    end else begin
                        n_build = 1'b0;
                        n_state = S_EMIT1;
                    end
                end
            end
            S_EMIT1: begin
                ram_req.raddr_a = '0;
                ram_req.raddr_b = AW'(r_size - CW'(1));
                n_state         = S_EMIT2;
            end
            S_EMIT2: begin
                ram_req.raddr_a = '0;
                ram_req.raddr_b = AW'(r_size - CW'(1));
                if (out_free) begin
                    n_ov       = 1'b1;
                    n_out_val  = rd_a;
                    n_out_last = (r_size == CW'(1));
                    n_size     = r_size - CW'(1);
                    if (r_size == CW'(1)) begin
                        n_state = S_LOAD;
                    end else begin
                        n_val           = rd_b;
                        n_node          = '0;
                        ram_req.raddr_a = AW'(1);
                        ram_req.raddr_b = AW'(2);
                        n_state         = S_CMP;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    assign o_stall     = (r_state != S_LOAD);
    assign o_valid     = r_ov;
    assign o_value_res = r_out_val;
    assign o_last_res  = r_out_last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt < CW'(DEPTH))
        else $error("element count out of range");

    a_cmp_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_size != '0) && (CW'(r_node) < r_size))
        else $error("sift node outside heap");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT2 && out_free) |=> r_ov)
        else $error("emitted item not registered");

    a_final_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT2 && out_free && r_size == CW'(1))
            |=> (r_state == S_LOAD) && (r_cnt == '0) && o_last_res)
        else $error("final item did not return to load");

endmodule
